[sv/bdd_pkg.sv]
// Shared types and constants of the balance and differential drive unit.
`default_nettype none
package bdd_pkg;

  localparam int DataW = 32;
  localparam int CfgIdxW = 3;
  localparam int InDataW = 224;
  localparam int OutDataW = 192;
  localparam int NumW = 66;   // wheel numerator width
  localparam int DivSteps = 66;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WHEEL_DIAMETER = 3'd0,
    REG_WHEEL_SPACING  = 3'd1,
    REG_MAX_SPEED      = 3'd2,
    REG_INCLINE_GAIN   = 3'd3,
    REG_GAIN_P         = 3'd4,
    REG_GAIN_I         = 3'd5,
    REG_LEG_MIN        = 3'd6,
    REG_LEG_MAX        = 3'd7
  } reg_idx_t;

  // Configuration image
  typedef struct packed {
    logic [30:0]        wheel_dia;
    logic [30:0]        wheel_spacing;
    logic [30:0]        speed_max;
    logic signed [31:0] incline_gain;
    logic signed [31:0] speed_gain_p;
    logic signed [31:0] speed_gain_i;
    logic signed [31:0] leg_min;
    logic signed [31:0] leg_max;
  } cfg_t;

  // Divider request and response
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num_mag;
    logic [30:0]     den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/balance_and_differential_drive_unit.sv]
// Top level: configuration, sequencer and output register of the drive unit.
// From request accepted to result valid: five multiply steps on one shared
// multiplier, two 66-step serial divisions and one clamp step.
// A new request is taken only when idle; in_tready is low while a tick
// is in work and while a result waits.
// Reset: synchronous active low; config registers to defaults, integral to 0.
`default_nettype none
module balance_and_differential_drive_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // target_speed, target_turn, target_incline, measured_incline,
  // measured_speed, front_leg_target, back_leg_target
  input  wire logic [223:0] in_tdata,
  // balance_mode, clear_integral, contacts[1:0]
  input  wire logic [3:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // front_left_wheel, front_right_wheel, back_left_wheel, back_right_wheel,
  // front_leg_command, back_leg_command
  output logic [191:0]      out_tdata
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MINC  = 10'b0000000010,
    S_VLIN  = 10'b0000000100,
    S_MP    = 10'b0000001000,
    S_MI    = 10'b0000010000,
    S_TURN  = 10'b0000100000,
    S_DIVL  = 10'b0001000000,
    S_DIVR  = 10'b0010000000,
    S_LEGS  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  bdd_pkg::cfg_t cfg_r;
  logic signed [31:0] integ_r;

  logic        bal_r;
  logic [1:0]  cont_r;
  logic signed [31:0] tspd_r, tturn_r, flt_r, blt_r, ierr_r, serr_r, vlin_r;
  logic signed [65:0] bias_r, turn_r;
  logic signed [31:0] left_r, right_r;
  logic        started_r;
  logic [191:0] out_r;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  bdd_pkg::div_req_t  dreq;
  bdd_pkg::div_rsp_t  drsp;
  logic signed [65:0] num;
  logic signed [65:0] qs, vmax, w;
  logic signed [31:0] ws;
  logic signed [31:0] isum;
  logic               div_go;

  bdd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  bdd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = out_r;

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MINC: begin mul_a = 33'(ierr_r); mul_b = cfg_r.incline_gain; end
      S_VLIN: begin mul_a = 33'(serr_r); mul_b = cfg_r.speed_gain_p; end
      S_MP:   begin mul_a = 33'(integ_r); mul_b = cfg_r.speed_gain_i; end
      S_MI, S_TURN: begin
        mul_a = 33'(tturn_r);
        mul_b = $signed({1'b0, cfg_r.wheel_spacing});
      end
      default: ;
    endcase
  end

  // Wheel numerator for the current side
  always_comb begin
    if (state_r == S_DIVR) num = (66'(vlin_r) <<< 17) + turn_r;
    else                   num = (66'(vlin_r) <<< 17) - turn_r;
    dreq.num_mag = num[65] ? 66'(-num) : num;
    dreq.den     = cfg_r.wheel_dia;
    dreq.start   = div_go;
  end

  // Sign, zero-divisor handling and clamp of a quotient
  always_comb begin
    vmax = 66'($signed({1'b0, cfg_r.speed_max}));
    qs   = num[65] ? -$signed(drsp.quo) : $signed(drsp.quo);
    if (cfg_r.wheel_dia == '0) begin
      if (num == '0) w = '0;
      else w = num[65] ? -vmax : vmax;
    end else if (qs > vmax) w = vmax;
    else if (qs < -vmax) w = -vmax;
    else w = qs;
    ws = w[31:0];
  end

  function automatic logic signed [31:0] leg_clamp(input logic signed [65:0] p,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
    logic signed [65:0] x;
    x = p;
    if (x < 66'(lo)) x = 66'(lo);
    if (x > 66'(hi)) x = 66'(hi);
    return x[31:0];
  endfunction

  logic signed [65:0] fpos, bpos;
  always_comb begin
    fpos = 66'(flt_r);
    bpos = 66'(blt_r);
    if (bal_r && cont_r[0]) fpos = fpos - bias_r;
    if (bal_r && cont_r[1]) bpos = bpos - bias_r;
    isum = bdd_pkg::sat32(66'(integ_r) + 66'(serr_r));
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    div_go    = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_MINC;
      S_MINC: state_nxt = S_VLIN;
      S_VLIN: state_nxt = S_MP;
      S_MP:   state_nxt = S_MI;
      S_MI:   state_nxt = S_TURN;
      S_TURN: begin state_nxt = S_DIVL; end
      S_DIVL: if (drsp.done && started_r) state_nxt = S_DIVR;
      S_DIVR: if (drsp.done && started_r) state_nxt = S_LEGS;
      S_LEGS: state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if ((state_r == S_DIVL || state_r == S_DIVR) && !started_r) div_go = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      integ_r   <= '0;
      cfg_r.wheel_dia       <= 31'd6554;
      cfg_r.wheel_spacing   <= 31'd13107;
      cfg_r.speed_max       <= 31'd655360;
      cfg_r.incline_gain    <= 32'sd65536;
      cfg_r.speed_gain_p    <= '0;
      cfg_r.speed_gain_i    <= '0;
      cfg_r.leg_min         <= -32'sd205887;
      cfg_r.leg_max         <= 32'sd205887;
    end else begin
      state_r <= state_nxt;
      // Write a configuration register
      if (cfg_valid) begin
        unique case (bdd_pkg::reg_idx_t'(cfg_index))
          bdd_pkg::REG_WHEEL_DIAMETER: cfg_r.wheel_dia       <= cfg_data[30:0];
          bdd_pkg::REG_WHEEL_SPACING:  cfg_r.wheel_spacing   <= cfg_data[30:0];
          bdd_pkg::REG_MAX_SPEED:      cfg_r.speed_max       <= cfg_data[30:0];
          bdd_pkg::REG_INCLINE_GAIN:   cfg_r.incline_gain    <= cfg_data;
          bdd_pkg::REG_GAIN_P:         cfg_r.speed_gain_p    <= cfg_data;
          bdd_pkg::REG_GAIN_I:         cfg_r.speed_gain_i    <= cfg_data;
          bdd_pkg::REG_LEG_MIN:        cfg_r.leg_min         <= cfg_data;
          bdd_pkg::REG_LEG_MAX:        cfg_r.leg_max         <= cfg_data;
          default: ;
        endcase
      end
      // Clear, then advance the integral in balance mode
      if (state_r == S_IDLE && in_tvalid) begin
        if (in_tuser[1]) integ_r <= '0;
      end
      if (state_r == S_MINC && bal_r) integ_r <= isum;
      if (div_go) started_r <= 1'b1;
      else if (drsp.done) started_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        bal_r   <= in_tuser[0];
        cont_r  <= in_tuser[3:2];
        tspd_r  <= in_tdata[31:0];
        tturn_r <= in_tdata[63:32];
        flt_r   <= in_tdata[191:160];
        blt_r   <= in_tdata[223:192];
        ierr_r  <= bdd_pkg::sat32(66'($signed(in_tdata[95:64]))
                                  - 66'($signed(in_tdata[127:96])));
        serr_r  <= bdd_pkg::sat32(66'($signed(in_tdata[31:0]))
                                  - 66'($signed(in_tdata[159:128])));
      end
      S_VLIN: vlin_r <= bal_r ? bdd_pkg::sat32(66'(mul_p >>> 16)) : tspd_r;
      S_MP:   bias_r <= 66'(mul_p >>> 16);
      S_MI:   bias_r <= bias_r + 66'(mul_p >>> 16);
      S_TURN: turn_r <= 66'(mul_p);
      S_DIVL: if (drsp.done && started_r) left_r <= ws;
      S_DIVR: if (drsp.done && started_r) right_r <= ws;
      S_LEGS: out_r <= {leg_clamp(bpos, cfg_r.leg_min, cfg_r.leg_max),
                        leg_clamp(fpos, cfg_r.leg_min, cfg_r.leg_max),
                        cont_r[1] ? right_r : 32'sd0,
                        cont_r[1] ? left_r : 32'sd0,
                        cont_r[0] ? right_r : 32'sd0,
                        cont_r[0] ? left_r : 32'sd0};
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[sv/bdd_div.sv]
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`default_nettype none
module bdd_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bdd_pkg::div_req_t req,
  output bdd_pkg::div_rsp_t      rsp
);

  logic [bdd_pkg::NumW-1:0] quo_r, quo_nxt;
  logic [31:0]              rem_r, rem_nxt;
  logic [6:0]               cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [31:0]              trial;

  // Shift in one numerator bit, subtract when it fits
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[30:0], quo_r[bdd_pkg::NumW-1]};
    if (req.start) begin
      quo_nxt  = req.num_mag;
      rem_nxt  = '0;
      cnt_nxt  = 7'(bdd_pkg::DivSteps);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, req.den}) begin
        rem_nxt = trial - {1'b0, req.den};
        quo_nxt = {quo_r[bdd_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[bdd_pkg::NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

[sv/bdd_mul.sv]
// Registered signed 33x32 multiplier shared by every product of a tick.
`default_nettype none
module bdd_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [64:0]      p
);

  // Register each product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire
